FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped during reset.
`define CHK_NOW(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, skipped during reset.
`define CHK_NEXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: sv/b32g_pkg.sv
package b32g_pkg;

  // Default characters per group before a space is inserted.
  localparam int GROUP_CHARS_DEF = 8;

  // Entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [6:0] SPACE_CHAR = 7'd32;
  localparam logic [6:0] CHAR_A     = 7'd65;
  localparam logic [6:0] CHAR_Z     = 7'd90;
  localparam logic [6:0] CHAR_2     = 7'd50;
  localparam logic [6:0] CHAR_7     = 7'd55;

  // One classified byte: up to two symbols with optional spaces ahead of them.
  typedef struct packed {
    logic       sp1;   // space before the first symbol
    logic [4:0] sym1;
    logic       two;   // second symbol present
    logic       sp2;   // space before the second symbol
    logic [4:0] sym2;
  } job_t;

  // Base32 alphabet: A-Z then 2-7.
  function automatic logic [6:0] sym_char(input logic [4:0] sym);
    logic [6:0] code;
    if (sym < 5'd26) begin
      code = CHAR_A + {2'b00, sym};
    end else begin
      code = CHAR_2 + {2'b00, sym - 5'd26};
    end
    return code;
  endfunction

endpackage

FILE: sv/b32g_front.sv
module b32g_front import b32g_pkg::*; #(
  parameter int GROUP_CHARS = GROUP_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       start_req,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  localparam int EFF_GROUP = (GROUP_CHARS < 2) ? 2 : GROUP_CHARS;
  localparam int GP_W      = $clog2(EFF_GROUP);
  localparam logic [GP_W-1:0] GP_LAST = GP_W'(EFF_GROUP - 1);

  logic [3:0]      store, store_next;
  logic [2:0]      count, count_next;
  logic [GP_W-1:0] gp, gp_next;
  logic            any_emitted;

  logic [3:0]      cur_store;
  logic [2:0]      cur_count;
  logic [GP_W-1:0] cur_gp, gp1;
  logic            cur_any;
  logic [11:0]     cat, sel1, sel2;
  logic [3:0]      cnt0, sh1_full;
  logic [2:0]      sh1, sh2;
  logic            two;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Start clears the running state ahead of this byte.
  always_comb begin
    cur_store = start_req ? 4'd0 : store;
    cur_count = start_req ? 3'd0 : count;
    cur_gp    = start_req ? '0 : gp;
    cur_any   = start_req ? 1'b0 : any_emitted;
  end

  // Split the new bits into one or two 5-bit symbols.
  always_comb begin
    cat      = {cur_store, data_byte};
    cnt0     = {1'b0, cur_count} + 4'd8;
    sh1_full = cnt0 - 4'd5;
    sh1      = sh1_full[2:0];
    sel1     = cat >> sh1;
    two      = (sh1 >= 3'd5);
    sh2      = sh1 - 3'd5;
    sel2     = cat >> sh2;
    count_next = two ? sh2 : sh1;
    store_next = cat[3:0] & 4'((5'd1 << count_next) - 5'd1);
  end

  // Group position and space placement.
  always_comb begin
    gp1 = (cur_gp == GP_LAST) ? '0 : cur_gp + 1'b1;
    if (two) begin
      gp_next = (gp1 == GP_LAST) ? '0 : gp1 + 1'b1;
    end else begin
      gp_next = gp1;
    end
    push_job.sp1  = cur_any && (cur_gp == '0);
    push_job.sym1 = sel1[4:0];
    push_job.two  = two;
    push_job.sp2  = two && (gp1 == '0);
    push_job.sym2 = sel2[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store       <= '0;
      count       <= '0;
      gp          <= '0;
      any_emitted <= 1'b0;
    end else if (push) begin
      store       <= store_next;
      count       <= count_next;
      gp          <= gp_next;
      any_emitted <= 1'b1;
    end
  end

endmodule

FILE: sv/b32g_queue.sv
module b32g_queue import b32g_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int QAW = (QUEUE_DEPTH < 2) ? 1 : $clog2(QUEUE_DEPTH);
  localparam logic [QAW-1:0] PTR_LAST = QAW'(QUEUE_DEPTH - 1);
  localparam logic [QAW:0]   CNT_FULL = (QAW + 1)'(QUEUE_DEPTH);

  job_t           entries [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   fill;

  assign full       = (fill == CNT_FULL);
  assign head_valid = (fill != '0);
  assign head_job   = entries[rd_ptr];

  // Payload storage, no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: sv/b32g_back.sv
module b32g_back import b32g_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] char_out,
  output logic       last
);

  logic [1:0] phase;
  logic [1:0] last_phase;
  logic [6:0] slot [3];
  logic [6:0] pick;
  logic       load, is_last;

  // Lay out the transaction sequence for the head job.
  always_comb begin
    slot[0] = sym_char(head_job.sym1);
    slot[1] = sym_char(head_job.sym2);
    slot[2] = sym_char(head_job.sym2);
    if (head_job.sp1) begin
      slot[0]    = SPACE_CHAR;
      slot[1]    = sym_char(head_job.sym1);
      last_phase = head_job.two ? 2'd2 : 2'd1;
    end else if (head_job.sp2) begin
      slot[1]    = SPACE_CHAR;
      last_phase = 2'd2;
    end else begin
      last_phase = head_job.two ? 2'd1 : 2'd0;
    end
    unique case (phase)
      2'd0:    pick = slot[0];
      2'd1:    pick = slot[1];
      default: pick = slot[2];
    endcase
  end

  assign load    = head_valid && (!out_valid || !out_stall);
  assign is_last = (phase == last_phase);
  assign pop     = load && is_last;

  // Output register and phase counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= is_last ? 2'd0 : phase + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_out <= pick;
      last     <= is_last;
    end
  end

endmodule

FILE: sv/base32_grouped_text_encoder_unit.sv
// Path: the first character of a byte passes through the job queue entry and then the output register.
// Throughput: one character per cycle from the output register while out_stall is low; a byte
// yields one to three characters, so the byte rate is set by the single character port.
// A two-entry job queue lets the front accept bytes while the back is still emitting.
// Reset (rst, synchronous): empties the queue and output, clears bit store and group count.
module base32_grouped_text_encoder_unit import b32g_pkg::*; #(
  parameter int GROUP_CHARS = GROUP_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       start_req,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] char_out,
  output logic       last
);

  logic push, q_full, pop, head_valid;
  job_t push_job, head_job;

  // Byte intake and symbol split.
  b32g_front #(
    .GROUP_CHARS(GROUP_CHARS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .start_req (start_req),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  // Job queue.
  b32g_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Character emitter.
  b32g_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_out   (char_out),
    .last       (last)
  );

endmodule

FILE: sv/b32g_checker.sv
`include "assert_macros.svh"

module b32g_checker import b32g_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] char_out,
  input logic       last
);

  // A stalled output transaction holds.
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(char_out) && $stable(last), "stalled output changed")

  // Only a space, a letter or a digit 2-7 leaves the block.
  `CHK_NOW(a_char_legal, clk, rst, out_valid,
    (char_out == SPACE_CHAR) || (char_out >= CHAR_A && char_out <= CHAR_Z) ||
    (char_out >= CHAR_2 && char_out <= CHAR_7), "illegal output character")

  // A space always precedes a character of the same byte.
  `CHK_NOW(a_space_not_last, clk, rst, out_valid && (char_out == SPACE_CHAR), !last,
    "space marked last")

  // A space never directly follows another space that was taken.
  `CHK_NOW(a_no_double_space, clk, rst,
    out_valid && (char_out == SPACE_CHAR) && $past(out_valid && !out_stall && !rst),
    $past(char_out) != SPACE_CHAR, "two spaces in a row")

endmodule

bind base32_grouped_text_encoder_unit b32g_checker u_b32g_checker (.*);
